[design/kvc_pkg.sv]
package kvc_pkg;

   localparam int unsigned ADC_BITS_DEFAULT      = 12;
   localparam int unsigned FRACTION_BITS_DEFAULT = 16;
   localparam int unsigned VOLUME_MAX_DEFAULT    = 127;

   localparam int unsigned GAIN_BITS      = 16;
   localparam int unsigned THR_BITS       = 7;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 16;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd13107;
   localparam logic [THR_BITS-1:0]  THR_RESET  = 7'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SMOOTHING_GAIN   = 1'd0,
      CSR_CHANGE_THRESHOLD = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic step;
   } filt_ctrl_type;

   // Number of volume steps k in 1..vol_max whose rounding midpoint lies at or
   // below the curve value for level a; this is the curve rounded half up.
   function automatic int unsigned curve_value(int unsigned a, int unsigned adc_bits,
                                               int unsigned vol_max);
      logic [127:0] m;
      logic [127:0] x;
      logic [127:0] v2;
      logic [127:0] lhs;
      logic [127:0] den;
      logic [127:0] o;
      logic [127:0] rhs;
      int unsigned  count;
      m     = (128'd1 << adc_bits) - 128'd1;
      x     = m - 128'(a);
      v2    = 128'(2 * vol_max);
      lhs   = x * x * x * v2 * v2 * v2 * v2 * v2;
      den   = m * m * m;
      count = 0;
      for (int unsigned k = 1; k <= vol_max; k++) begin
         o   = 128'(2 * k - 1);
         rhs = o * o * o * o * o * den;
         if (lhs >= rhs) begin
            count++;
         end
      end
      return count;
   endfunction

endpackage

[design/knob_volume_conditioner_unit.sv]
// Volume knob conditioner. Each word on the req_ channel carries one raw
// converter reading of the knob. The first reading after reset loads the
// smoothing filter directly; later readings are folded in with an exponential
// moving average weighted by the smoothing gain register. The integer level of
// the filter is mapped to a volume through a power-curve ROM, and the result
// word on the rsp_ channel carries the volume, the smoothed level and a flag
// in rsp_tuser that marks a volume that is newly reported.
// Each accepted word gives exactly one result word; it passes through the input
// register, filter register, ROM output register and result register in that
// order. A new word may be accepted every cycle while rsp_tready holds high, so
// the sustained rate is one word per cycle; the filter update and the reported
// volume each close their loop through their own registered state.
// When the receiver holds rsp_tready low, words close up in the empty stages
// and req_tready falls only once all four stages are full.
// Reset clears the stages, filter and reported volume and restores gain and
// threshold defaults. csr_ writes a register when csr_we is high, reset low;
// the user is to write it only while the block is idle; this is not enforced.
module knob_volume_conditioner_unit #(
   parameter int unsigned ADC_BITS      = kvc_pkg::ADC_BITS_DEFAULT,
   parameter int unsigned FRACTION_BITS = kvc_pkg::FRACTION_BITS_DEFAULT,
   parameter int unsigned VOLUME_MAX    = kvc_pkg::VOLUME_MAX_DEFAULT,
   parameter int unsigned VOL_BITS      = $clog2(VOLUME_MAX + 1),
   parameter int unsigned REQ_W         = ((ADC_BITS + 7) / 8) * 8,
   parameter int unsigned RSP_W         = ((VOL_BITS + ADC_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // adc_sample
   input  logic [REQ_W-1:0]                   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // volume_level, smoothed_level
   output logic [RSP_W-1:0]                   rsp_tdata,
   // volume_changed
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [kvc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kvc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import kvc_pkg::*;

   logic [GAIN_BITS-1:0] gain_ff;
   logic [THR_BITS-1:0]  thr_ff;
   logic                 a_valid_ff;
   logic                 b_valid_ff;
   logic                 c_valid_ff;
   logic                 d_valid_ff;
   logic                 a_ready;
   logic                 b_ready;
   logic                 c_ready;
   logic                 d_ready;
   filt_ctrl_type        filt_ctrl;
   logic [ADC_BITS-1:0]  filt_level;
   logic [ADC_BITS-1:0]  c_level_ff;
   logic [VOL_BITS-1:0]  rom_vol;
   logic [VOL_BITS-1:0]  out_vol;
   logic                 out_changed;
   logic [ADC_BITS-1:0]  out_level;

   always_comb begin
      d_ready        = !d_valid_ff || rsp_tready;
      c_ready        = !c_valid_ff || d_ready;
      b_ready        = !b_valid_ff || c_ready;
      a_ready        = !a_valid_ff || b_ready;
      filt_ctrl.load = req_tvalid && a_ready;
      filt_ctrl.step = a_valid_ff && b_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= GAIN_RESET;
         thr_ff     <= THR_RESET;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SMOOTHING_GAIN:   gain_ff <= csr_wdata[GAIN_BITS-1:0];
               CSR_CHANGE_THRESHOLD: thr_ff  <= csr_wdata[THR_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (a_ready) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff && c_ready) begin
         c_level_ff <= filt_level;
      end
   end

   kvc_filter #(
      .ADC_BITS      (ADC_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_filter (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (filt_ctrl),
      .sample (req_tdata[ADC_BITS-1:0]),
      .gain   (gain_ff),
      .level  (filt_level)
   );

   kvc_curve_rom #(
      .ADC_BITS   (ADC_BITS),
      .VOLUME_MAX (VOLUME_MAX),
      .VOL_BITS   (VOL_BITS)
   ) u_curve_rom (
      .clock (clock),
      .rd_en (b_valid_ff && c_ready),
      .addr  (filt_level),
      .data  (rom_vol)
   );

   kvc_report #(
      .ADC_BITS (ADC_BITS),
      .VOL_BITS (VOL_BITS)
   ) u_report (
      .clock       (clock),
      .reset       (reset),
      .en          (c_valid_ff && d_ready),
      .vol         (rom_vol),
      .level       (c_level_ff),
      .threshold   (thr_ff),
      .vol_out     (out_vol),
      .changed_out (out_changed),
      .level_out   (out_level)
   );

   assign req_tready = a_ready;
   assign rsp_tvalid = d_valid_ff;
   assign rsp_tdata  = RSP_W'({out_level, out_vol});
   assign rsp_tuser  = out_changed;

endmodule

[design/kvc_filter.sv]
module kvc_filter #(
   parameter int unsigned ADC_BITS      = kvc_pkg::ADC_BITS_DEFAULT,
   parameter int unsigned FRACTION_BITS = kvc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kvc_pkg::filt_ctrl_type        ctrl,
   input  logic [ADC_BITS-1:0]           sample,
   input  logic [kvc_pkg::GAIN_BITS-1:0] gain,
   output logic [ADC_BITS-1:0]           level
);
   import kvc_pkg::*;

   localparam int unsigned FILT_W = ADC_BITS + FRACTION_BITS;
   localparam int unsigned PROD_W = FILT_W + GAIN_BITS + 2;
   localparam logic [FILT_W-1:0] TOP = {{ADC_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (GAIN_BITS - 1);

   logic [ADC_BITS-1:0]      sample_ff;
   logic [FILT_W-1:0]        filt_ff;
   logic [FILT_W-1:0]        filt_in;
   logic                     seen_ff;
   logic [FILT_W-1:0]        target;
   logic signed [FILT_W:0]   delta;
   logic signed [GAIN_BITS:0] gain_s;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] shifted;
   logic signed [FILT_W+1:0] next;

   always_comb begin
      target  = {sample_ff, {FRACTION_BITS{1'b0}}};
      delta   = $signed({1'b0, target}) - $signed({1'b0, filt_ff});
      gain_s  = $signed({1'b0, gain});
      prod    = delta * gain_s;
      rounded = prod + $signed(HALF);
      shifted = rounded >>> GAIN_BITS;
      next    = $signed({2'b00, filt_ff}) + shifted[FILT_W+1:0];
      if (!seen_ff) begin
         filt_in = target;
      end else if (next[FILT_W+1]) begin
         filt_in = '0;
      end else if (next[FILT_W:0] > {1'b0, TOP}) begin
         filt_in = TOP;
      end else begin
         filt_in = next[FILT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sample_ff <= sample;
      end
      if (reset) begin
         filt_ff <= '0;
         seen_ff <= 1'b0;
      end else if (ctrl.step) begin
         filt_ff <= filt_in;
         seen_ff <= 1'b1;
      end
   end

   assign level = filt_ff[FILT_W-1 -: ADC_BITS];

endmodule

[design/kvc_curve_rom.sv]
module kvc_curve_rom #(
   parameter int unsigned ADC_BITS   = kvc_pkg::ADC_BITS_DEFAULT,
   parameter int unsigned VOLUME_MAX = kvc_pkg::VOLUME_MAX_DEFAULT,
   parameter int unsigned VOL_BITS   = $clog2(VOLUME_MAX + 1)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADC_BITS-1:0] addr,
   output logic [VOL_BITS-1:0] data
);
   import kvc_pkg::*;

   localparam int unsigned DEPTH = 1 << ADC_BITS;

   logic [VOL_BITS-1:0] lut [DEPTH];
   logic [VOL_BITS-1:0] data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_lut
      assign lut[i] = VOL_BITS'(curve_value(i, ADC_BITS, VOLUME_MAX));
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= lut[addr];
      end
   end

   assign data = data_ff;

endmodule

[design/kvc_report.sv]
module kvc_report #(
   parameter int unsigned ADC_BITS = kvc_pkg::ADC_BITS_DEFAULT,
   parameter int unsigned VOL_BITS = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [VOL_BITS-1:0]          vol,
   input  logic [ADC_BITS-1:0]          level,
   input  logic [kvc_pkg::THR_BITS-1:0] threshold,
   output logic [VOL_BITS-1:0]          vol_out,
   output logic                         changed_out,
   output logic [ADC_BITS-1:0]          level_out
);
   import kvc_pkg::*;

   localparam int unsigned CMP_W = (VOL_BITS > THR_BITS) ? VOL_BITS : THR_BITS;

   logic [VOL_BITS-1:0] reported_ff;
   logic                seen_ff;
   logic [VOL_BITS-1:0] vol_ff;
   logic                changed_ff;
   logic [ADC_BITS-1:0] level_ff;
   logic [VOL_BITS-1:0] diff;
   logic                changed_in;

   always_comb begin
      diff       = (vol >= reported_ff) ? (vol - reported_ff) : (reported_ff - vol);
      changed_in = !seen_ff || (CMP_W'(diff) >= CMP_W'(threshold));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vol_ff     <= vol;
         changed_ff <= changed_in;
         level_ff   <= level;
      end
      if (reset) begin
         reported_ff <= '0;
         seen_ff     <= 1'b0;
      end else if (en && changed_in) begin
         reported_ff <= vol;
         seen_ff     <= 1'b1;
      end
   end

   assign vol_out     = vol_ff;
   assign changed_out = changed_ff;
   assign level_out   = level_ff;

endmodule
